[rtl/core/rcpp_pkg.sv]
// Shared types and constants of the row and column projection profile block.
// Used by every module under rtl/core but rcpp_ram; depends on nothing else.
package rcpp_pkg;

    localparam int PIX_W  = 8;
    localparam int SUM_W  = 18;
    localparam int POS_W  = 10;
    localparam int DEN_W  = 11;
    localparam int CFG_W  = 11;
    // Wide enough to hold a frame size up to the largest supported maximum.
    localparam int SIZE_W = 13;

    localparam int MAX_COLUMNS_DEFAULT = 1024;
    localparam int MAX_ROWS_DEFAULT    = 1024;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd1024;

    // Division by 255: multiply by 257 / 2^16, then one correction step.
    localparam int DIVISOR    = 255;
    localparam int RECIP      = 257;
    localparam int RECIP_SH   = 16;
    localparam int PROD_W     = SUM_W + 9;

    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_COLUMN = 1'b1;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_ROW_ENABLE    = 2'd2,
        REG_COLUMN_ENABLE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] position;
        logic [DEN_W-1:0] density;
        logic             last;
    } res_t;

    // Up to two results that one pixel causes, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } pair_t;

endpackage

[rtl/core/rcpp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; a read during a write to the same address returns old data.
module rcpp_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/rcpp_div255.sv]
// Two-step divider of an 18-bit line sum by 255: registered reciprocal
// product, then a single correction. Depends on rcpp_pkg.
module rcpp_div255 (
    input  logic                      clk,
    input  logic                      en,
    input  logic [rcpp_pkg::SUM_W-1:0] sum_i,
    output logic [rcpp_pkg::DEN_W-1:0] den_o
);
    import rcpp_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum_reg;
    logic [DEN_W-1:0]  quo_reg;
    logic [SUM_W:0]    quo_x255;
    logic [SUM_W:0]    rem;

    assign prod = PROD_W'(sum_i) * PROD_W'(RECIP);

    always_ff @(posedge clk) begin
        if (en) begin
            sum_reg <= sum_i;
            quo_reg <= prod[RECIP_SH +: DEN_W];
        end
    end

    // The estimate is the true quotient or one below it.
    assign quo_x255 = {quo_reg, 8'b0} - (SUM_W + 1)'(quo_reg);
    assign rem      = {1'b0, sum_reg} - quo_x255;
    assign den_o    = (rem >= (SUM_W + 1)'(DIVISOR)) ? quo_reg + 1'b1 : quo_reg;

endmodule

[rtl/core/rcpp_out.sv]
// Output queue of two result slots feeding the result channel.
// Depends on rcpp_pkg for the result and pair types.
module rcpp_out (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  rcpp_pkg::pair_t            in_pair,
    output logic                       in_ready,
    output logic                       two_pending,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_kind,
    output logic [rcpp_pkg::POS_W-1:0] m_position,
    output logic [rcpp_pkg::DEN_W-1:0] m_density,
    output logic                       m_last
);
    import rcpp_pkg::*;

    logic [1:0] cnt_reg;
    res_t       slot0_reg;
    res_t       slot1_reg;
    logic       pop;
    logic       load;

    assign pop      = (cnt_reg != 2'd0) && m_ready;
    assign in_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= in_pair.count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot0_reg <= in_pair.first;
            slot1_reg <= in_pair.second;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

    assign two_pending = (cnt_reg == 2'd2);
    assign m_valid     = (cnt_reg != 2'd0);
    assign m_kind      = slot0_reg.kind;
    assign m_position  = slot0_reg.position;
    assign m_density   = slot0_reg.density;
    assign m_last      = slot0_reg.last;

endmodule

[rtl/core/row_column_projection_profile.sv]
// Top level of the row and column projection profile block.
// Depends on rcpp_pkg, rcpp_ram, rcpp_div255 and rcpp_out.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_pixel
// m_        out        m_valid / m_ready  m_kind, m_position, m_density, m_last
// apb       in         psel / penable     paddr, pwdata, pwrite; prdata out
//
// One pixel is taken per cycle while nothing holds it off; its results pass through
// stage 1, stage 2 and the output queue. A pixel that causes two results fills both
// output slots, the only thing besides m_ready that can hold off a pixel transfer.
// Reset is synchronous and active low; the column store is not cleared, since
// the first row of every frame writes each entry before it is read.
module row_column_projection_profile #(
    parameter int MAX_COLUMNS = rcpp_pkg::MAX_COLUMNS_DEFAULT,
    parameter int MAX_ROWS    = rcpp_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rcpp_pkg::PIX_W-1:0]      s_pixel,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_kind,
    output logic [rcpp_pkg::POS_W-1:0]      m_position,
    output logic [rcpp_pkg::DEN_W-1:0]      m_density,
    output logic                            m_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rcpp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rcpp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rcpp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import rcpp_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_ROWS);

    // Configuration registers.
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic             row_enable_reg;
    logic             column_enable_reg;
    logic             cfg_write;
    reg_idx_t         cfg_idx;

    // Stage 0: counters and the running row sum, updated on each pixel transfer.
    logic [CW-1:0]     col_cnt_reg;
    logic [RW-1:0]     row_cnt_reg;
    logic [SUM_W-1:0]  row_sum_reg;
    logic [SUM_W-1:0]  row_sum_next;
    logic [SIZE_W-1:0] width_ext;
    logic [SIZE_W-1:0] height_ext;
    logic [SIZE_W-1:0] width_eff;
    logic [SIZE_W-1:0] height_eff;
    logic [CW-1:0]     col_last;
    logic [RW-1:0]     row_last;
    logic [CW-1:0]     col_cur;
    logic [RW-1:0]     row_cur;
    logic              at_last_col;
    logic              at_last_row;
    logic              accept;

    // Stage 1: column store read data arrives; read-modify-write happens here.
    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pixel_reg;
    logic [CW-1:0]     s1_col_reg;
    logic [RW-1:0]     s1_row_reg;
    logic              s1_first_row_reg;
    logic              s1_emit_row_reg;
    logic              s1_emit_col_reg;
    logic [SUM_W-1:0]  s1_row_sum_reg;
    logic              fwd_hit_reg;
    logic [SUM_W-1:0]  fwd_data_reg;
    logic [SUM_W-1:0]  ram_rdata;
    logic [SUM_W-1:0]  col_prev;
    logic [SUM_W-1:0]  col_sum;
    logic              ram_we;
    logic              s1_adv;

    // Stage 2: quotients are corrected and the results are assembled.
    logic              s2_valid_reg;
    logic [CW-1:0]     s2_col_reg;
    logic [RW-1:0]     s2_row_reg;
    logic              s2_emit_row_reg;
    logic              s2_emit_col_reg;
    logic              s2_adv;
    logic [DEN_W-1:0]  row_den;
    logic [DEN_W-1:0]  col_den;
    res_t              row_res;
    res_t              col_res;
    pair_t             pair;
    logic              out_ready;
    logic              out_two_pending;

    // ------------------------------------------------------------------
    // Configuration port. Every write completes in its access cycle.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= FRAME_WIDTH_RESET;
            frame_height_reg  <= FRAME_HEIGHT_RESET;
            row_enable_reg    <= 1'b1;
            column_enable_reg <= 1'b1;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_FRAME_WIDTH:   frame_width_reg   <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= pwdata[CFG_W-1:0];
                REG_ROW_ENABLE:    row_enable_reg    <= pwdata[0];
                REG_COLUMN_ENABLE: column_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_FRAME_WIDTH:   prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT:  prdata = APB_DATA_W'(frame_height_reg);
            REG_ROW_ENABLE:    prdata = APB_DATA_W'(row_enable_reg);
            REG_COLUMN_ENABLE: prdata = APB_DATA_W'(column_enable_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 0. A size of zero behaves as one, and a size above the maximum
    // behaves as the maximum. A counter left beyond the last index by a size
    // change mid-frame is treated as sitting on the last index.
    // ------------------------------------------------------------------
    assign width_ext  = SIZE_W'(frame_width_reg);
    assign height_ext = SIZE_W'(frame_height_reg);

    always_comb begin
        if (width_ext == '0) begin
            width_eff = SIZE_W'(1);
        end else if (width_ext > SIZE_W'(MAX_COLUMNS)) begin
            width_eff = SIZE_W'(MAX_COLUMNS);
        end else begin
            width_eff = width_ext;
        end
        if (height_ext == '0) begin
            height_eff = SIZE_W'(1);
        end else if (height_ext > SIZE_W'(MAX_ROWS)) begin
            height_eff = SIZE_W'(MAX_ROWS);
        end else begin
            height_eff = height_ext;
        end
    end

    assign col_last    = CW'(width_eff - SIZE_W'(1));
    assign row_last    = RW'(height_eff - SIZE_W'(1));
    assign col_cur     = (col_cnt_reg > col_last) ? col_last : col_cnt_reg;
    assign row_cur     = (row_cnt_reg > row_last) ? row_last : row_cnt_reg;
    assign at_last_col = (col_cur == col_last);
    assign at_last_row = (row_cur == row_last);

    assign accept  = s_valid && s_ready;
    assign s_ready = s1_adv;

    // The first pixel of a row restarts the row sum; the sum wraps at 18 bits.
    assign row_sum_next = (col_cur == '0) ? SUM_W'(s_pixel)
                                          : row_sum_reg + SUM_W'(s_pixel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            row_sum_reg <= '0;
        end else if (accept) begin
            row_sum_reg <= row_sum_next;
            if (at_last_col) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= at_last_row ? '0 : row_cur + 1'b1;
            end else begin
                col_cnt_reg <= col_cur + 1'b1;
                row_cnt_reg <= row_cur;
            end
        end
    end

    // ------------------------------------------------------------------
    // Column store. The read is issued with the pixel transfer, and the
    // updated sum is written back as the pixel leaves stage 1. When the
    // frame is one column wide, that write lands on the very edge at which
    // the next pixel reads the same entry, so the written value is forwarded.
    // ------------------------------------------------------------------
    rcpp_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLUMNS)
    ) u_col_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata (col_sum),
        .re    (accept),
        .raddr (col_cur),
        .rdata (ram_rdata)
    );

    assign s2_adv   = !s2_valid_reg || out_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign ram_we   = s1_valid_reg && s2_adv;
    assign col_prev = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign col_sum  = s1_first_row_reg ? SUM_W'(s1_pixel_reg)
                                       : col_prev + SUM_W'(s1_pixel_reg);

    // The forward flag follows stage 1, so it drops when stage 1 empties.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (s1_adv) begin
                s1_valid_reg <= accept;
                fwd_hit_reg  <= accept && ram_we && (s1_col_reg == col_cur);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pixel_reg     <= s_pixel;
            s1_col_reg       <= col_cur;
            s1_row_reg       <= row_cur;
            s1_first_row_reg <= (row_cur == '0);
            s1_emit_row_reg  <= at_last_col && row_enable_reg;
            s1_emit_col_reg  <= at_last_row && column_enable_reg;
            s1_row_sum_reg   <= row_sum_next;
            fwd_data_reg     <= col_sum;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2. Both line sums are divided by 255 side by side.
    // ------------------------------------------------------------------
    rcpp_div255 u_row_div (
        .clk   (aclk),
        .en    (ram_we),
        .sum_i (s1_row_sum_reg),
        .den_o (row_den)
    );

    rcpp_div255 u_col_div (
        .clk   (aclk),
        .en    (ram_we),
        .sum_i (col_sum),
        .den_o (col_den)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            s2_col_reg      <= s1_col_reg;
            s2_row_reg      <= s1_row_reg;
            s2_emit_row_reg <= s1_emit_row_reg;
            s2_emit_col_reg <= s1_emit_col_reg;
        end
    end

    // On the last pixel of the frame the row result goes first.
    always_comb begin
        row_res.kind     = KIND_ROW;
        row_res.position = POS_W'(s2_row_reg);
        row_res.density  = row_den;
        row_res.last     = !s2_emit_col_reg;
        col_res.kind     = KIND_COLUMN;
        col_res.position = POS_W'(s2_col_reg);
        col_res.density  = col_den;
        col_res.last     = 1'b1;
        pair.count       = 2'(s2_emit_row_reg) + 2'(s2_emit_col_reg);
        pair.first       = s2_emit_row_reg ? row_res : col_res;
        pair.second      = col_res;
    end

    rcpp_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s2_valid_reg),
        .in_pair     (pair),
        .in_ready    (out_ready),
        .two_pending (out_two_pending),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_position  (m_position),
        .m_density   (m_density),
        .m_last      (m_last)
    );

`ifndef SYNTHESIS
    // A forwarded column sum only ever serves a pixel sitting in stage 1.
    a_fwd_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forwarded column sum without a pixel in stage 1");

    // A row result that is not the last of its pixel has a column result behind it.
    a_row_then_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_ROW) && !m_last) |-> out_two_pending)
        else $error("row result not marked last without a following column result");

    // The column counter never leaves the column store's address range.
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (CW + 1)'(col_cnt_reg) < (CW + 1)'(MAX_COLUMNS))
        else $error("column counter beyond the column store");

    // The column store is written only when a pixel leaves stage 1.
    a_write_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (s2_valid_reg && ($past(s1_col_reg) == s2_col_reg)))
        else $error("column store write without the pixel moving to stage 2");
`endif

endmodule

[tb/sv/row_column_projection_profile_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of row_column_projection_profile: streams pixel frames
// through the s_ channel and checks every row and column density on m_.
// Depends on rcpp_pkg and the row_column_projection_profile RTL only.
module row_column_projection_profile_test;
    import rcpp_pkg::*;

    localparam int COLUMNS         = MAX_COLUMNS_DEFAULT;
    localparam int ROWS            = MAX_ROWS_DEFAULT;
    localparam int RANDOM_PIXELS   = 900;
    localparam int PRESSURE_PIXELS = 200;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int REPORT_LIMIT    = 10;

    // How the pixel values of one phase are drawn.
    typedef enum int {
        PIX_UNIFORM,
        PIX_BRIGHT,
        PIX_DARK,
        PIX_EXTREME,
        PIX_FULL
    } pixel_mix_t;

    // Every input of the block starts at a known value.
    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic [PIX_W-1:0]      s_pixel = '0;
    logic                  m_ready = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;

    logic                  s_ready;
    logic                  m_valid;
    logic                  m_kind;
    logic [POS_W-1:0]      m_position;
    logic [DEN_W-1:0]      m_density;
    logic                  m_last;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    row_column_projection_profile DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel    (s_pixel),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_position (m_position),
        .m_density  (m_density),
        .m_last     (m_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 aclk = ~aclk;

    // Pixels waiting to be offered, and densities waiting to come out.
    logic [PIX_W-1:0] pixel_queue[$];
    res_t             density_queue[$];

    // Our own copy of the block: configuration, column store, row sum, counters.
    logic [CFG_W-1:0] frame_w_reg = FRAME_WIDTH_RESET;
    logic [CFG_W-1:0] frame_h_reg = FRAME_HEIGHT_RESET;
    logic             row_on      = 1'b1;
    logic             col_on      = 1'b1;
    logic [SUM_W-1:0] column_totals [COLUMNS];
    bit               column_filled [COLUMNS];
    logic [SUM_W-1:0] row_total = '0;
    int unsigned      at_column = 0;
    int unsigned      at_row    = 0;

    // Bookkeeping shared by the processes below.
    int unsigned pixels_queued   = 0;
    int unsigned pixels_accepted = 0;
    int unsigned row_checks      = 0;
    int unsigned column_checks   = 0;
    int unsigned failures        = 0;
    int unsigned phases          = 0;
    int unsigned reg_writes      = 0;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;
    int unsigned send_gap        = 0;
    int unsigned recv_gap        = 0;
    int unsigned stall_mark      = 32'hFFFF_FFFF;
    logic        receiver_hold   = 1'b0;

    function automatic void report_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("[%0t] FAIL: %s", $realtime, msg);
    endfunction

    // A size register of 0 behaves as 1, and one above the maximum as the maximum.
    function automatic int unsigned effective_size(input int unsigned raw, input int unsigned top);
        if (raw < 1)
            return 1;
        if (raw > top)
            return top;
        return raw;
    endfunction

    // Pixels still needed to reach the end of the current frame.
    function automatic int unsigned pixels_to_frame_end();
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        w = effective_size(frame_w_reg, COLUMNS);
        h = effective_size(frame_h_reg, ROWS);
        c = (at_column > w - 1) ? w - 1 : at_column;
        r = (at_row > h - 1) ? h - 1 : at_row;
        return (h - 1 - r) * w + (w - c);
    endfunction

    // True when every column below n has been written at least once since reset.
    function automatic bit columns_filled(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            if (!column_filled[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Value a register read is expected to return.
    function automatic logic [APB_DATA_W-1:0] register_image(input reg_idx_t idx);
        case (idx)
            REG_FRAME_WIDTH:  return APB_DATA_W'(frame_w_reg);
            REG_FRAME_HEIGHT: return APB_DATA_W'(frame_h_reg);
            REG_ROW_ENABLE:   return APB_DATA_W'(row_on);
            default:          return APB_DATA_W'(col_on);
        endcase
    endfunction

    // Advances the projection by one accepted pixel and queues the densities it
    // produces. Counters past the last index in use are treated as sitting on it,
    // which covers a frame size that shrank in the middle of a frame.
    function automatic void project_pixel(input logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        logic             row_end;
        logic             frame_bottom;
        logic             give_row;
        logic             give_col;
        logic [SUM_W-1:0] col_total;
        res_t             res;
        w = effective_size(frame_w_reg, COLUMNS);
        h = effective_size(frame_h_reg, ROWS);
        c = (at_column > w - 1) ? w - 1 : at_column;
        r = (at_row > h - 1) ? h - 1 : at_row;
        row_end      = (c == w - 1);
        frame_bottom = (r == h - 1);

        // The first row loads each column, the first column loads the row.
        if (r == 0)
            column_totals[c] = SUM_W'(px);
        else
            column_totals[c] = column_totals[c] + SUM_W'(px);
        column_filled[c] = 1'b1;
        col_total = column_totals[c];
        if (c == 0)
            row_total = SUM_W'(px);
        else
            row_total = row_total + SUM_W'(px);

        // The enables only gate what is sent; the sums keep accumulating.
        give_row = row_end && row_on;
        give_col = frame_bottom && col_on;
        if (give_row) begin
            res.kind     = KIND_ROW;
            res.position = POS_W'(r);
            res.density  = DEN_W'(row_total / DIVISOR);
            res.last     = !give_col;
            density_queue.push_back(res);
        end
        if (give_col) begin
            res.kind     = KIND_COLUMN;
            res.position = POS_W'(c);
            res.density  = DEN_W'(col_total / DIVISOR);
            res.last     = 1'b1;
            density_queue.push_back(res);
        end

        if (row_end) begin
            at_column = 0;
            at_row    = frame_bottom ? 0 : r + 1;
        end else begin
            at_column = c + 1;
            at_row    = r;
        end
    endfunction

    function automatic logic [PIX_W-1:0] next_pixel(input pixel_mix_t mix);
        case (mix)
            PIX_BRIGHT:  return PIX_W'($urandom_range(200, 255));
            PIX_DARK:    return PIX_W'($urandom_range(0, 40));
            PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            PIX_FULL:    return 8'd255;
            default:     return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void offer_pixel(input logic [PIX_W-1:0] px);
        pixel_queue.push_back(px);
        pixels_queued++;
    endfunction

    function automatic void offer_pixels(input int unsigned count, input pixel_mix_t mix);
        for (int unsigned i = 0; i < count; i++)
            offer_pixel(next_pixel(mix));
        phases++;
    endfunction

    task automatic apb_read(input reg_idx_t idx, output logic [APB_DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes one register (random junk above the field, which the block drops),
    // mirrors it into the predictor and reads it back.
    task automatic set_register(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        logic [APB_DATA_W-1:0] readback;
        word = ($urandom_range(0, 1) != 0) ? APB_DATA_W'($urandom()) : '0;
        word[CFG_W-1:0] = value;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
        case (idx)
            REG_FRAME_WIDTH:  frame_w_reg = word[CFG_W-1:0];
            REG_FRAME_HEIGHT: frame_h_reg = word[CFG_W-1:0];
            REG_ROW_ENABLE:   row_on      = word[0];
            default:          col_on      = word[0];
        endcase
        apb_read(idx, readback);
        if (readback !== register_image(idx))
            report_failure($sformatf("register %s read 0x%0h, expected 0x%0h",
                idx.name(), readback, register_image(idx)));
    endtask

    // Returns once every queued pixel has been taken and every density has come
    // out, then lets the pipeline run dry, since the last pixels may emit nothing.
    task automatic wait_idle();
        while (pixels_accepted != pixels_queued || density_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Sender. A pixel stays on s_ until its transfer; between transfers it may
    // take a random break.
    always @(posedge aclk) begin : pixel_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                project_pixel(s_pixel);
                pixels_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pixel_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_pixel <= pixel_queue.pop_front();
                    if ($urandom_range(1, 100) <= send_idle_pct)
                        send_gap = $urandom_range(1, 10);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Each density transfer is compared with the oldest prediction;
    // m_ready drops in random bursts and during the long hold-off.
    always @(posedge aclk) begin : density_monitor
        res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (m_kind == KIND_ROW)
                    row_checks++;
                else
                    column_checks++;
                if (density_queue.size() == 0) begin
                    report_failure($sformatf(
                        "unexpected density: kind %0d position %0d density %0d last %0d",
                        m_kind, m_position, m_density, m_last));
                end else begin
                    want = density_queue.pop_front();
                    if (m_kind !== want.kind || m_position !== want.position ||
                        m_density !== want.density || m_last !== want.last)
                        report_failure($sformatf(
                            {"density mismatch: expected kind %0d position %0d density %0d",
                             " last %0d, got kind %0d position %0d density %0d last %0d"},
                            want.kind, want.position, want.density, want.last,
                            m_kind, m_position, m_density, m_last));
                end
            end
            if (receiver_hold) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(1, 100) <= recv_idle_pct)
                    recv_gap = $urandom_range(1, 10);
            end
        end
    end

    // Long hold-off of the receiver while the widest frame streams in, so the
    // output fills up and the block has to stall its pixel input.
    initial begin : receiver_hold_off
        int unsigned held;
        wait (pixels_accepted >= stall_mark);
        @(posedge aclk);
        receiver_hold <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++)
            @(posedge aclk);
        receiver_hold <= 1'b0;
    end

    initial begin : run_limit
        #5_000_000;
        $display("Timeout: %0d of %0d pixels taken, %0d densities outstanding.",
            pixels_accepted, pixels_queued, density_queue.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [APB_DATA_W-1:0] word;
        logic [CFG_W-1:0]      w_raw;
        logic [CFG_W-1:0]      h_raw;
        bit                    write_w;
        bit                    write_h;
        int unsigned           random_pixels;
        int unsigned           frame;
        int unsigned           count;
        int unsigned           h_next;
        int unsigned           pick;
        pixel_mix_t            mix;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Registers must come up at their reset values.
        for (int i = 0; i < 4; i++) begin
            apb_read(reg_idx_t'(i), word);
            if (word !== register_image(reg_idx_t'(i)))
                report_failure($sformatf("register %0d reads 0x%0h after reset", i, word));
        end

        // 3x2 frame with black, white and mid-gray pixels; the corner pixel gives
        // a row density followed by a column density.
        set_register(REG_FRAME_WIDTH, 11'd3);
        set_register(REG_FRAME_HEIGHT, 11'd2);
        set_register(REG_ROW_ENABLE, 11'd1);
        set_register(REG_COLUMN_ENABLE, 11'd1);
        offer_pixel(8'd0);
        offer_pixel(8'd255);
        offer_pixel(8'd128);
        offer_pixel(8'd255);
        offer_pixel(8'd255);
        offer_pixel(8'd1);
        phases++;

        // Row densities switched off: only the column ones may appear.
        wait_idle();
        set_register(REG_ROW_ENABLE, 11'd0);
        set_register(REG_FRAME_WIDTH, 11'd2);
        repeat (4) offer_pixel(8'd255);
        phases++;

        // Column densities switched off instead.
        wait_idle();
        set_register(REG_ROW_ENABLE, 11'd1);
        set_register(REG_COLUMN_ENABLE, 11'd0);
        offer_pixel(8'd255);
        offer_pixel(8'd0);
        offer_pixel(8'd85);
        offer_pixel(8'd170);
        phases++;

        // Zero sizes behave as a 1x1 frame: two densities per pixel.
        wait_idle();
        set_register(REG_COLUMN_ENABLE, 11'd1);
        set_register(REG_FRAME_WIDTH, 11'd0);
        set_register(REG_FRAME_HEIGHT, 11'd0);
        offer_pixel(8'd255);
        offer_pixel(8'd0);
        offer_pixel(8'd254);
        phases++;

        // Stop inside a 4x3 frame at row 1, column 1, then shrink the frame to
        // 2x2 so both counters land on the last index in use.
        wait_idle();
        set_register(REG_FRAME_WIDTH, 11'd4);
        set_register(REG_FRAME_HEIGHT, 11'd3);
        repeat (4) offer_pixel(8'd255);
        offer_pixel(8'd200);
        phases++;
        wait_idle();
        set_register(REG_FRAME_WIDTH, 11'd2);
        set_register(REG_FRAME_HEIGHT, 11'd2);
        offer_pixel(8'd60);
        offer_pixel(8'd70);
        offer_pixel(8'd80);
        phases++;

        // Part of one row of the widest frame, a single row high so every pixel
        // gives a column density. The receiver holds off for a while during it.
        wait_idle();
        set_register(REG_FRAME_HEIGHT, 11'd1);
        set_register(REG_FRAME_WIDTH, 11'h7FF);
        set_register(REG_ROW_ENABLE, 11'd1);
        set_register(REG_COLUMN_ENABLE, 11'd1);
        stall_mark = pixels_accepted + 20;
        offer_pixels(PRESSURE_PIXELS, PIX_FULL);
        wait_idle();
        // A narrow frame ends the unfinished wide row on its next pixel.
        set_register(REG_FRAME_WIDTH, 11'd8);

        // Random phases: small frames, mostly whole ones, some cut off midway so
        // the next configuration change lands inside a frame.
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            wait_idle();

            // Idling varies from phase to phase and stops near the end of the run.
            if (random_pixels >= RANDOM_PIXELS * 4 / 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                pick = $urandom_range(0, 3);
                send_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 30 : 60;
                pick = $urandom_range(0, 3);
                recv_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 30 : 60;
            end

            w_raw   = frame_w_reg;
            h_raw   = frame_h_reg;
            write_w = ($urandom_range(0, 99) < 60);
            write_h = ($urandom_range(0, 99) < 60);
            if (write_w) begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    w_raw = 11'd0;
                else if (pick < 80)
                    w_raw = CFG_W'($urandom_range(1, 8));
                else
                    w_raw = CFG_W'($urandom_range(9, 40));
            end
            if (write_h) begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    h_raw = 11'd0;
                else if (pick < 75)
                    h_raw = CFG_W'($urandom_range(1, 6));
                else
                    h_raw = CFG_W'($urandom_range(7, 16));
            end
            // Past the first row a column is read back, so a frame may only widen
            // there onto columns that already hold data.
            h_next = effective_size(h_raw, ROWS);
            if (((at_row < h_next - 1) ? at_row : h_next - 1) != 0) begin
                while (!columns_filled(effective_size(w_raw, COLUMNS))) begin
                    w_raw   = w_raw - 1'b1;
                    write_w = 1'b1;
                end
            end
            if (write_w)
                set_register(REG_FRAME_WIDTH, w_raw);
            if (write_h)
                set_register(REG_FRAME_HEIGHT, h_raw);
            if ($urandom_range(0, 99) < 60)
                set_register(REG_ROW_ENABLE, CFG_W'($urandom_range(0, 3) != 0));
            if ($urandom_range(0, 99) < 60)
                set_register(REG_COLUMN_ENABLE, CFG_W'($urandom_range(0, 3) != 0));

            frame = effective_size(frame_w_reg, COLUMNS) * effective_size(frame_h_reg, ROWS);
            count = pixels_to_frame_end();
            if (frame <= 150)
                count += frame * $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, count);
            mix = pixel_mix_t'($urandom_range(0, 3));
            offer_pixels(count, mix);
            random_pixels += count;
        end

        wait_idle();
        repeat (16) @(posedge aclk);
        $display("Covered %0d pixels in %0d phases with %0d register writes.",
            pixels_accepted, phases, reg_writes);
        $display("Checked %0d row and %0d column densities; %0d failures.",
            row_checks, column_checks, failures);
        if (failures == 0 && density_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[row_column_projection_profile.f]
rtl/core/rcpp_pkg.sv
rtl/core/rcpp_ram.sv
rtl/core/rcpp_div255.sv
rtl/core/rcpp_out.sv
rtl/core/row_column_projection_profile.sv
tb/sv/row_column_projection_profile_test.sv
